>>> src/lkbe_pkg.sv
// Shared types, constants and the segment table for the ladder keypad byte editor.
package lkbe_pkg;

	localparam int SampleW    = 8;
	localparam int ValueW     = 8;
	localparam int NumLevels  = 6;
	localparam int CfgIndexW  = 3;
	localparam int FrameBits  = 16;
	localparam int BitIdxW    = 4;
	localparam int QueueDepth = 2;

	localparam logic [SampleW-1:0] LevelReset [NumLevels] = '{
		8'h30, 8'h60, 8'h80, 8'hB0, 8'hD0, 8'hF0
	};

	localparam logic [ValueW-1:0] StepHigh = 8'h10;
	localparam logic [ValueW-1:0] StepLow  = 8'h01;
	localparam logic [ValueW-1:0] ValueMax = 8'hFF;

	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
	} q_wr_t;

	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
	} q_rd_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'h0: code = 8'hFC;
			4'h1: code = 8'h60;
			4'h2: code = 8'hDA;
			4'h3: code = 8'hF2;
			4'h4: code = 8'h66;
			4'h5: code = 8'hB6;
			4'h6: code = 8'hBE;
			4'h7: code = 8'hE0;
			4'h8: code = 8'hFE;
			4'h9: code = 8'hE6;
			4'hA: code = 8'hEE;
			4'hB: code = 8'h3E;
			4'hC: code = 8'h9C;
			4'hD: code = 8'h7A;
			4'hE: code = 8'h9E;
			4'hF: code = 8'h8E;
			default: code = 8'hFC;
		endcase
		return code;
	endfunction

endpackage

>>> src/lkbe_front.sv
// Front end: threshold registers, key decode, press arming and byte update.
module lkbe_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [lkbe_pkg::SampleW-1:0]        sample,
	output logic                                full,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lkbe_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [lkbe_pkg::SampleW-1:0]        cfg_data,
	input  logic                                q_full,
	output lkbe_pkg::q_wr_t                     q_wr
);

	typedef enum logic [2:0] {
		KEY_NONE,
		KEY_UP_HIGH,
		KEY_DOWN_HIGH,
		KEY_UP_LOW,
		KEY_DOWN_LOW,
		KEY_DISARM,
		KEY_CLEAR
	} key_t;

	logic [lkbe_pkg::SampleW-1:0] levels_q [lkbe_pkg::NumLevels];
	logic [lkbe_pkg::ValueW-1:0]  value_q;
	logic                         armed_q;
	key_t                         key;
	logic [lkbe_pkg::ValueW-1:0]  next_value;
	logic [lkbe_pkg::ValueW-1:0]  new_value;
	logic [lkbe_pkg::ValueW:0]    sum_high;
	logic [lkbe_pkg::ValueW:0]    sum_low;
	logic                         accept;
	logic                         acts;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;

	always_comb begin
		key = KEY_NONE;
		for (int k = lkbe_pkg::NumLevels - 1; k >= 0; k--) begin
			if (sample < levels_q[k]) begin
				key = key_t'(3'(k + 1));
			end
		end
	end

	assign sum_high = {1'b0, value_q} + {1'b0, lkbe_pkg::StepHigh};
	assign sum_low  = {1'b0, value_q} + {1'b0, lkbe_pkg::StepLow};

	always_comb begin
		case (key)
			KEY_UP_HIGH: begin
				next_value = sum_high[lkbe_pkg::ValueW] ? lkbe_pkg::ValueMax
					: sum_high[lkbe_pkg::ValueW-1:0];
			end
			KEY_DOWN_HIGH: begin
				next_value = (value_q > lkbe_pkg::StepHigh) ? value_q - lkbe_pkg::StepHigh
					: '0;
			end
			KEY_UP_LOW: begin
				next_value = sum_low[lkbe_pkg::ValueW] ? lkbe_pkg::ValueMax
					: sum_low[lkbe_pkg::ValueW-1:0];
			end
			KEY_DOWN_LOW: begin
				next_value = (value_q > lkbe_pkg::StepLow) ? value_q - lkbe_pkg::StepLow
					: '0;
			end
			KEY_CLEAR: begin
				next_value = '0;
			end
			default: begin
				next_value = value_q;
			end
		endcase
	end

	assign acts      = armed_q && (key != KEY_NONE);
	assign new_value = acts ? next_value : value_q;

	assign q_wr.valid = accept;
	assign q_wr.value = new_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			armed_q <= 1'b0;
			for (int k = 0; k < lkbe_pkg::NumLevels; k++) begin
				levels_q[k] <= lkbe_pkg::LevelReset[k];
			end
		end else begin
			if (cfg_valid && cfg_ready && (cfg_index < lkbe_pkg::CfgIndexW'(lkbe_pkg::NumLevels))) begin
				levels_q[cfg_index] <= cfg_data;
			end
			if (accept) begin
				if (key == KEY_NONE) begin
					armed_q <= 1'b1;
				end else if (armed_q) begin
					armed_q <= 1'b0;
					value_q <= next_value;
				end
			end
		end
	end

endmodule

>>> src/lkbe_queue.sv
// Short queue of updated byte values between the front end and the serialiser.
module lkbe_queue #(
	parameter int DEPTH = lkbe_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lkbe_pkg::q_wr_t wr,
	output logic            q_full,
	output lkbe_pkg::q_rd_t rd,
	input  logic            take
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [lkbe_pkg::ValueW-1:0] mem_q [DEPTH];
	logic [IW-1:0]               wr_ptr_q;
	logic [IW-1:0]               rd_ptr_q;
	logic [CW-1:0]               count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign q_full   = (count_q == CW'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.value = mem_q[rd_ptr_q];
	assign do_wr    = wr.valid && !q_full;
	assign do_rd    = take && rd.valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/lkbe_serial.sv
// Back end: sixteen-bit display frame serialiser with registered output.
module lkbe_serial (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkbe_pkg::q_rd_t               rd,
	output logic                          take,
	output logic                          empty,
	input  logic                          pop,
	output logic                          data_level,
	output logic                          frame_end,
	output logic [lkbe_pkg::ValueW-1:0]   shown_value
);

	localparam logic [lkbe_pkg::BitIdxW-1:0] LastBit = lkbe_pkg::BitIdxW'(lkbe_pkg::FrameBits - 1);

	logic                          busy_q;
	logic [lkbe_pkg::BitIdxW-1:0]  bit_q;
	logic [lkbe_pkg::ValueW-1:0]   value_q;
	logic [lkbe_pkg::FrameBits-1:0] frame;
	logic                          out_fire;
	logic                          last;

	assign frame = {lkbe_pkg::seg_code(value_q[7:4]), lkbe_pkg::seg_code(value_q[3:0])};

	assign empty       = !busy_q;
	assign data_level  = ~frame[bit_q];
	assign frame_end   = (bit_q == LastBit);
	assign shown_value = value_q;

	assign out_fire = pop && busy_q;
	assign last     = out_fire && (bit_q == LastBit);
	assign take     = rd.valid && (!busy_q || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			bit_q   <= '0;
			value_q <= '0;
		end else begin
			if (take) begin
				busy_q  <= 1'b1;
				bit_q   <= '0;
				value_q <= rd.value;
			end else if (last) begin
				busy_q <= 1'b0;
				bit_q  <= '0;
			end else if (out_fire) begin
				bit_q <= bit_q + 1'b1;
			end
		end
	end

endmodule

>>> src/ladder_keypad_byte_editor.sv
// Top level of the ladder keypad byte editor.
// Each sample pushed in is decoded against six threshold registers, may edit the stored
// byte, and yields sixteen result items, the display frame bit by bit with the frame
// end flag on the last one. Results leave at one item per cycle while pop is high, and
// the serialiser takes the next sample only once the last item of its frame is popped.
// A sample is taken whenever the QUEUE_DEPTH-entry queue in front of the serialiser has
// room; if the serialiser is free, the sample is written into the queue and then loaded
// into the serialiser's registers, which put its first result on the outputs.
module ladder_keypad_byte_editor #(
	parameter int QUEUE_DEPTH = lkbe_pkg::QueueDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [lkbe_pkg::SampleW-1:0]      sample,
	output logic                              empty,
	input  logic                              pop,
	output logic                              data_level,
	output logic                              frame_end,
	output logic [lkbe_pkg::ValueW-1:0]       shown_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkbe_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [lkbe_pkg::SampleW-1:0]      cfg_data
);

	lkbe_pkg::q_wr_t q_wr;
	lkbe_pkg::q_rd_t q_rd;
	logic            q_full;
	logic            take;

	lkbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	lkbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.q_full (q_full),
		.rd     (q_rd),
		.take   (take)
	);

	lkbe_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (q_rd),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.data_level  (data_level),
		.frame_end   (frame_end),
		.shown_value (shown_value)
	);

endmodule

>>> src/lkbe_checker.sv
// Port-level checker for the ladder keypad byte editor, bound to the top level.
module lkbe_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic                         data_level,
	input logic                         frame_end,
	input logic [lkbe_pkg::ValueW-1:0]  shown_value
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_level) && $stable(frame_end)
			&& $stable(shown_value)))
		else $error("stalled item changed");

	a_frame_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !frame_end) |=> (!empty && $stable(shown_value)))
		else $error("frame broken before its last item");

	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> !frame_end)
		else $error("frame started on its last item");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |-> ##2 !empty)
		else $error("pushed item did not reach the output");

endmodule

bind ladder_keypad_byte_editor lkbe_checker u_lkbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.data_level  (data_level),
	.frame_end   (frame_end),
	.shown_value (shown_value)
);

>>> verif/tb_ladder_keypad_byte_editor.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ladder keypad byte editor: frame predictor, scoreboard and stimulus.

typedef enum int {
	KeyNone,
	KeyUpSixteen,
	KeyDownSixteen,
	KeyUpOne,
	KeyDownOne,
	KeyDisarm,
	KeyClear
} key_e;

typedef enum logic [lkbe_pkg::CfgIndexW-1:0] {
	RegKeyOne,
	RegKeyTwo,
	RegKeyThree,
	RegKeyFour,
	RegKeyFive,
	RegKeySix,
	RegSpareA,
	RegSpareB
} level_reg_e;

typedef struct packed {
	logic                          data_level;
	logic                          frame_end;
	logic [lkbe_pkg::ValueW-1:0]   shown_value;
} frame_bit_t;

class frame_checker;
	logic [lkbe_pkg::SampleW-1:0] levels [lkbe_pkg::NumLevels];
	logic [lkbe_pkg::ValueW-1:0]  stored_byte;
	bit                           armed;
	frame_bit_t                   due_bits [$];
	logic [7:0]                   seg_pattern [16] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
		8'hFE, 8'hE6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
	};
	int errors = 0;
	int bits_checked = 0;
	int samples_noted = 0;
	int clamp_hits = 0;
	int acted [7];

	function new();
		foreach (levels[i]) levels[i] = lkbe_pkg::LevelReset[i];
		foreach (acted[i]) acted[i] = 0;
		stored_byte = '0;
		armed = 1'b0;
	endfunction

	function key_e decode_key(logic [lkbe_pkg::SampleW-1:0] s);
		for (int k = 0; k < lkbe_pkg::NumLevels; k++) begin
			if (s < levels[k]) return key_e'(k + 1);
		end
		return KeyNone;
	endfunction

	function void set_level(logic [lkbe_pkg::CfgIndexW-1:0] idx, logic [7:0] data);
		if (idx < lkbe_pkg::NumLevels) levels[idx] = data;
	endfunction

	function logic [7:0] bump_up(logic [7:0] v, logic [7:0] d);
		logic [8:0] wide;
		wide = {1'b0, v} + {1'b0, d};
		if (wide[8]) begin
			clamp_hits++;
			return 8'hFF;
		end
		return wide[7:0];
	endfunction

	function logic [7:0] bump_down(logic [7:0] v, logic [7:0] d);
		if (v < d) begin
			clamp_hits++;
			return 8'h00;
		end
		return v - d;
	endfunction

	function void note_sample(logic [lkbe_pkg::SampleW-1:0] s);
		key_e       key;
		logic [15:0] frame;
		frame_bit_t fb;
		key = decode_key(s);
		samples_noted++;
		if (key == KeyNone) begin
			armed = 1'b1;
		end else if (armed) begin
			armed = 1'b0;
			acted[key]++;
			case (key)
				KeyUpSixteen:   stored_byte = bump_up(stored_byte, 8'h10);
				KeyDownSixteen: stored_byte = bump_down(stored_byte, 8'h10);
				KeyUpOne:       stored_byte = bump_up(stored_byte, 8'h01);
				KeyDownOne:     stored_byte = bump_down(stored_byte, 8'h01);
				KeyClear:       stored_byte = 8'h00;
				default:        ;
			endcase
		end
		frame = {seg_pattern[stored_byte[7:4]], seg_pattern[stored_byte[3:0]]};
		for (int b = 0; b < lkbe_pkg::FrameBits; b++) begin
			fb.data_level = ~frame[b];
			fb.frame_end = (b == lkbe_pkg::FrameBits - 1);
			fb.shown_value = stored_byte;
			due_bits.push_back(fb);
		end
	endfunction

	function void check_bit(logic dl, logic fe, logic [lkbe_pkg::ValueW-1:0] sv);
		frame_bit_t want;
		bits_checked++;
		if (due_bits.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("Unexpected frame bit: level %0b end %0b value %02h", dl, fe, sv);
			return;
		end
		want = due_bits.pop_front();
		if (want.data_level !== dl || want.frame_end !== fe || want.shown_value !== sv) begin
			errors++;
			if (errors <= 10)
				$display({"Frame bit mismatch: expected level %0b end %0b value %02h,",
					" got level %0b end %0b value %02h"},
					want.data_level, want.frame_end, want.shown_value, dl, fe, sv);
		end
	endfunction

	function int pending();
		return due_bits.size();
	endfunction
endclass

module tb_ladder_keypad_byte_editor;

	localparam int StallLimit   = 3000;
	localparam int SettleCycles = 8;

	localparam logic [7:0] DirectedSamples [25] = '{
		8'd0,   8'd255, 8'd47,  8'd240, 8'd48,
		8'd255, 8'd95,  8'd250, 8'd96,  8'd248,
		8'd127, 8'd255, 8'd128, 8'd255, 8'd175,
		8'd255, 8'd175, 8'd255, 8'd176, 8'd100,
		8'd255, 8'd30,  8'd255, 8'd208, 8'd239
	};

	typedef enum int {
		LevelsAscending,
		LevelsAllHigh,
		LevelsAllLow,
		LevelsScrambled
	} level_plan_e;

	typedef struct {
		level_reg_e index;
		logic [7:0] data;
	} cfg_write_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             push = 1'b0;
	logic                             full;
	logic [lkbe_pkg::SampleW-1:0]     sample = '0;
	logic                             empty;
	logic                             pop = 1'b0;
	logic                             data_level;
	logic                             frame_end;
	logic [lkbe_pkg::ValueW-1:0]      shown_value;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [lkbe_pkg::CfgIndexW-1:0]   cfg_index = '0;
	logic [lkbe_pkg::SampleW-1:0]     cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	int level_writes = 0;
	int phases_run = 0;
	cfg_write_t cfg_plan [$];
	frame_checker board = new();

	ladder_keypad_byte_editor dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.sample,
		.empty,
		.pop,
		.data_level,
		.frame_end,
		.shown_value,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				board.note_sample(sample);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				board.check_bit(data_level, frame_end, shown_value);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				board.set_level(cfg_index, cfg_data);
				level_writes++;
				moved = 1'b1;
			end
			if (moved) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < StallLimit) @(posedge clk);
		$display("No handshake for %0d cycles", StallLimit);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_sample(input logic [lkbe_pkg::SampleW-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	function automatic logic [7:0] sample_for(key_e k);
		logic [7:0] s;
		if (k != KeyNone && $urandom_range(3) == 0) begin
			s = board.levels[int'(k) - 1] - 8'd1;
			if (board.decode_key(s) == k) return s;
		end
		repeat (96) begin
			s = 8'($urandom_range(255));
			if (board.decode_key(s) == k) return s;
		end
		return s;
	endfunction

	function automatic void queue_write(level_reg_e idx, int data);
		cfg_write_t w;
		w.index = idx;
		w.data = data[7:0];
		cfg_plan.push_back(w);
	endfunction

	task automatic apply_cfg_plan();
		foreach (cfg_plan[i]) begin
			if (i == 0) cfg_valid <= 1'b1;
			cfg_index <= cfg_plan[i].index;
			cfg_data <= cfg_plan[i].data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cfg_plan.delete();
	endtask

	task automatic settle();
		while (board.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic drive_random(input int n);
		int   sent;
		int   r;
		int   presses;
		key_e k;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				k = key_e'($urandom_range(1, 6));
				presses = ($urandom_range(7) == 0) ? $urandom_range(4, 18) : 1;
				repeat (presses) begin
					send_sample(sample_for(KeyNone));
					send_sample(sample_for(k));
					sent += 2;
					if ($urandom_range(3) == 0) begin
						send_sample(sample_for(k));
						sent++;
					end
				end
			end else if (r < 85) begin
				send_sample(sample_for(key_e'($urandom_range(1, 6))));
				sent++;
			end else begin
				send_sample(8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	task automatic run_phase(input level_plan_e plan, input int spct, input int rpct,
		input int n);
		int lv;
		case (plan)
			LevelsAscending: begin
				lv = $urandom_range(0, 60);
				for (int i = 0; i < lkbe_pkg::NumLevels; i++) begin
					queue_write(level_reg_e'(i), lv);
					lv = lv + $urandom_range(8, 45);
					if (lv > 255) lv = 255;
				end
			end
			LevelsAllHigh: begin
				for (int i = 0; i < lkbe_pkg::NumLevels; i++) queue_write(level_reg_e'(i), 8'hFF);
			end
			LevelsAllLow: begin
				queue_write(RegSpareA, $urandom_range(255));
				for (int i = 0; i < lkbe_pkg::NumLevels; i++) queue_write(level_reg_e'(i), 8'h00);
				queue_write(RegSpareB, $urandom_range(255));
			end
			default: begin
				for (int i = 0; i < lkbe_pkg::NumLevels; i++)
					queue_write(level_reg_e'(i), $urandom_range(255));
				queue_write(RegSpareB, 8'hFF);
				queue_write(RegSpareA, 8'h00);
			end
		endcase
		apply_cfg_plan();
		send_idle_pct = spct;
		recv_stall_pct = rpct;
		phases_run++;
		drive_random(n);
		push <= 1'b0;
		settle();
	endtask

	initial begin
		int failures;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		phases_run = 1;
		foreach (DirectedSamples[i]) send_sample(DirectedSamples[i]);
		push <= 1'b0;
		settle();
		run_phase(LevelsAscending, 0, 0, 100);
		run_phase(LevelsAllHigh, 84, 0, 70);
		run_phase(LevelsAllLow, 0, 84, 40);
		run_phase(LevelsScrambled, 37, 37, 110);
		run_phase(LevelsAscending, 37, 37, 75);
		failures = board.errors + board.pending();
		$display("Covered %0d samples, %0d frame bits and %0d level writes over %0d phases.",
			board.samples_noted, board.bits_checked, level_writes, phases_run);
		$display("Keys acted: +16 %0d, -16 %0d, +1 %0d, -1 %0d, disarm %0d, clear %0d;%s%0d.",
			board.acted[KeyUpSixteen], board.acted[KeyDownSixteen], board.acted[KeyUpOne],
			board.acted[KeyDownOne], board.acted[KeyDisarm], board.acted[KeyClear],
			" clamped ", board.clamp_hits);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
